// ===== rtl/core/magic_length_frame_detector_top_defines.svh =====
// ----------------------------------------------------------------------------
// Magic length frame detector assertion macros
// Shared assertion shorthands for the frame detector checker.
// ----------------------------------------------------------------------------
`ifndef MAGIC_LENGTH_FRAME_DETECTOR_TOP_DEFINES_SVH
`define MAGIC_LENGTH_FRAME_DETECTOR_TOP_DEFINES_SVH

// property checked outside reset only
`define MLFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define MLFD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mlfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Magic length frame detector package
// Shared constants, command codes and types of the frame detector.
// ----------------------------------------------------------------------------
package mlfd_pkg;

	// header layout
	localparam int MAGIC_BYTES  = 8;
	localparam int HEADER_BYTES = 14;
	localparam int LEN_CHARS    = 4;
	localparam int LEN_POS      = MAGIC_BYTES + 1;
	localparam int LEN_END      = (LEN_POS + LEN_CHARS > HEADER_BYTES) ?
		HEADER_BYTES : LEN_POS + LEN_CHARS;

	// widths
	localparam int LEN_W  = 14;
	localparam int FILL_W = $clog2(HEADER_BYTES + 1);

	// command queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 14'd288;
	localparam logic             REG_MAX_LEN   = 1'b0;

	// magic text, first character at index 0
	localparam logic [0:7][7:0] MAGIC_TEXT = {
		8'h58, 8'h6F, 8'h50, 8'h55, 8'h32, 8'h34, 8'h54, 8'h6B
	};

	// characters of the length field
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// func codes at the input port
	localparam logic [1:0] FUNC_BYTE   = 2'd0;
	localparam logic [1:0] FUNC_ARM    = 2'd1;
	localparam logic [1:0] FUNC_DISARM = 2'd2;

	// queued operations
	typedef logic [1:0] op_t;
	localparam op_t OP_BYTE   = 2'd0;
	localparam op_t OP_ARM    = 2'd1;
	localparam op_t OP_DISARM = 2'd2;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	// head of the command queue
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

endpackage

// ===== rtl/core/mlfd_front.sv =====
// ----------------------------------------------------------------------------
// Frame detector front end
// Accepts input words, decodes func into queue commands, drops unused codes.
// ----------------------------------------------------------------------------
module mlfd_front import mlfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;
	logic is_cmd;
	op_t  op_dec;

	// decode func; unused code carries no command
	always_comb begin
		is_cmd = 1'b1;
		op_dec = OP_BYTE;
		case (func)
			FUNC_BYTE:   op_dec = OP_BYTE;
			FUNC_ARM:    op_dec = OP_ARM;
			FUNC_DISARM: op_dec = OP_DISARM;
			default:     is_cmd = 1'b0;
		endcase
	end

	assign in_stall = valid_s1 & q_full;
	assign accept   = in_valid & ~in_stall;
	assign push     = valid_s1 & ~q_full;
	assign push_cmd = cmd_s1;

	// decode stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= is_cmd;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// decode stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op   <= op_dec;
			cmd_s1.data <= rx_byte;
		end
	end

endmodule

// ===== rtl/core/mlfd_queue.sv =====
// ----------------------------------------------------------------------------
// Frame detector command queue
// Small FIFO that decouples the front end from the detector back end.
// ----------------------------------------------------------------------------
module mlfd_queue import mlfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   push_cmd,
	output logic   q_full,
	input  logic   pop,
	output qhead_t head
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];
	assign do_push    = push & ~q_full;
	assign do_pop     = pop & head.valid;

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/core/mlfd_back.sv =====
// ----------------------------------------------------------------------------
// Frame detector back end
// Header window, magic match, length parse, payload count and result register.
// ----------------------------------------------------------------------------
module mlfd_back import mlfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  qhead_t           head,
	output logic             pop,
	input  logic [LEN_W-1:0] max_len,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [LEN_W-1:0] payload_len,
	output logic [LEN_W-1:0] frame_len
);

	// length parser phases
	localparam logic [1:0] PH_SKIP = 2'd0;
	localparam logic [1:0] PH_DIG  = 2'd1;
	localparam logic [1:0] PH_END  = 2'd2;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// strtol-like parse of the length characters; returns {neg, value}
	function automatic logic [LEN_W:0] parse_len(input logic [HEADER_BYTES-1:0][7:0] w);
		logic [LEN_W-1:0] val;
		logic             neg;
		logic [1:0]       phase;
		logic [7:0]       c;
		val   = '0;
		neg   = 1'b0;
		phase = PH_SKIP;
		for (int i = LEN_POS; i < LEN_END; i++) begin
			c = w[i];
			case (phase)
				PH_SKIP: begin
					if (is_space(c)) begin
						phase = PH_SKIP;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						neg   = (c == CH_MINUS);
						phase = PH_DIG;
					end else if (is_digit(c)) begin
						val   = {{(LEN_W-4){1'b0}}, c[3:0]};
						phase = PH_DIG;
					end else begin
						phase = PH_END;
					end
				end
				PH_DIG: begin
					if (is_digit(c)) begin
						val = (val << 3) + (val << 1) + {{(LEN_W-4){1'b0}}, c[3:0]};
					end else begin
						phase = PH_END;
					end
				end
				default: phase = PH_END;
			endcase
		end
		return {neg, val};
	endfunction

	logic [HEADER_BYTES-1:0][7:0] win_q;
	logic [FILL_W-1:0]            fill_q;
	logic                         armed_q;
	logic                         locked_q;
	logic [LEN_W-1:0]             decl_q;
	logic [LEN_W-1:0]             seen_q;
	logic                         done_q;
	logic                         out_valid_q;
	logic [LEN_W-1:0]             payload_len_q;
	logic [LEN_W-1:0]             frame_len_q;

	logic [HEADER_BYTES-1:0][7:0] w_next;
	logic                         take_byte;
	logic                         win_full;
	logic                         magic_ok;
	logic [LEN_W:0]               parsed;
	logic                         len_bad;
	logic [LEN_W-1:0]             seen_inc;
	logic                         frame_end;
	logic                         emit;

	// one command per cycle while the result register can take a result
	assign pop       = head.valid & (~out_valid_q | ~out_stall);
	assign take_byte = pop & (head.cmd.op == OP_BYTE) & armed_q & ~done_q;

	// window with the incoming byte placed at the fill position
	always_comb begin
		w_next = win_q;
		for (int i = 0; i < HEADER_BYTES; i++) begin
			if (fill_q == FILL_W'(i)) w_next[i] = head.cmd.data;
		end
	end

	// header checks on the completed window
	always_comb begin
		magic_ok = 1'b1;
		for (int i = 0; i < MAGIC_BYTES; i++) begin
			if (w_next[i] != MAGIC_TEXT[i]) magic_ok = 1'b0;
		end
	end

	assign win_full  = (fill_q == FILL_W'(HEADER_BYTES - 1));
	assign parsed    = parse_len(w_next);
	assign len_bad   = parsed[LEN_W] | (parsed[LEN_W-1:0] == '0) |
		(parsed[LEN_W-1:0] > max_len);
	assign seen_inc  = seen_q + 1'b1;
	assign frame_end = (seen_inc >= decl_q);
	assign emit      = take_byte & locked_q & frame_end;

	// detector control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			armed_q  <= 1'b0;
			locked_q <= 1'b0;
			decl_q   <= '0;
			seen_q   <= '0;
			done_q   <= 1'b0;
		end else if (pop) begin
			case (head.cmd.op)
				OP_ARM: begin
					fill_q   <= '0;
					armed_q  <= 1'b1;
					locked_q <= 1'b0;
					decl_q   <= '0;
					seen_q   <= '0;
					done_q   <= 1'b0;
				end
				OP_DISARM: armed_q <= 1'b0;
				OP_BYTE: begin
					if (take_byte) begin
						if (locked_q) begin
							seen_q <= seen_inc;
							if (frame_end) done_q <= 1'b1;
						end else if (!win_full) begin
							fill_q <= fill_q + 1'b1;
						end else if (!magic_ok) begin
							fill_q <= FILL_W'(HEADER_BYTES - 1);
						end else if (len_bad) begin
							fill_q <= FILL_W'(HEADER_BYTES - MAGIC_BYTES);
						end else begin
							fill_q   <= FILL_W'(HEADER_BYTES);
							locked_q <= 1'b1;
							decl_q   <= parsed[LEN_W-1:0];
							seen_q   <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// header window: append, or drop one byte or the magic from the front
	always_ff @(posedge clk) begin
		if (take_byte && !locked_q) begin
			if (!win_full || (magic_ok && !len_bad)) begin
				win_q <= w_next;
			end else if (!magic_ok) begin
				win_q <= w_next >> 8;
			end else begin
				win_q <= w_next >> (8 * MAGIC_BYTES);
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			payload_len_q <= decl_q;
			frame_len_q   <= decl_q + LEN_W'(HEADER_BYTES);
		end
	end

	assign out_valid   = out_valid_q;
	assign payload_len = payload_len_q;
	assign frame_len   = frame_len_q;

endmodule

// ===== rtl/core/magic_length_frame_detector_top.sv =====
// ----------------------------------------------------------------------------
// Magic length frame detector
// Finds a magic-led header in a byte stream and reports the frame length.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while in_stall is low: func 0 carries a
// received byte, func 1 arms the detector and clears the header window, func 2
// disarms it, func 3 is ignored. Words pass a decode stage and a four-word
// command queue; the detector drains one queue word per cycle, so the
// sustained rate is one word per clock, held back only while a finished
// result waits in the output register. A received byte passes the decode
// stage register and the queue before it reaches the detector; the result it
// completes is registered and appears in the cycle after. One result
// (payload_len, frame_len) is given per armed frame. Register 0 at byte address
// 0 holds max_payload_len (reset 288); write it while the block is idle.
module magic_length_frame_detector_top import mlfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// input words
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       func,
	input  logic [7:0]       rx_byte,
	// results
	output logic             out_valid,
	input  logic             out_stall,
	output logic [LEN_W-1:0] payload_len,
	output logic [LEN_W-1:0] frame_len,
	// register port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic             q_full;
	logic             push;
	cmd_t             push_cmd;
	logic             pop;
	qhead_t           head;
	logic [LEN_W-1:0] max_len_q;

	// register write and readback
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN) begin
			max_len_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MAX_LEN) ? {{(32-LEN_W){1'b0}}, max_len_q} : '0;

	mlfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mlfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full),
		.pop      (pop),
		.head     (head)
	);

	mlfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.max_len     (max_len_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.payload_len (payload_len),
		.frame_len   (frame_len)
	);

endmodule

// ===== rtl/core/mlfd_checker.sv =====
// ----------------------------------------------------------------------------
// Frame detector port checker
// Port-level assertions on the frame detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "magic_length_frame_detector_top_defines.svh"

module mlfd_checker import mlfd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic [LEN_W-1:0] payload_len,
	input logic [LEN_W-1:0] frame_len,
	input logic             psel,
	input logic             penable,
	input logic             pwrite,
	input logic [2:0]       paddr,
	input logic [31:0]      pwdata,
	input logic [31:0]      prdata,
	input logic             pready
);

	// no result shows while reset is held
	`MLFD_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid, "result valid during reset")

	// a stalled result stays put
	`MLFD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(payload_len) && $stable(frame_len), "stalled result changed")

	// frame length is payload plus header
	`MLFD_ASSERT(a_frame_len, out_valid |-> frame_len == payload_len + 14'd14, "frame_len mismatch")

	// a written limit reads back on the next cycle
	`MLFD_ASSERT(a_cfg_readback, psel && penable && pwrite && pready && !paddr[2] |=> paddr[2] || prdata[13:0] == $past(pwdata[13:0]), "limit readback mismatch")

endmodule

bind magic_length_frame_detector_top mlfd_checker u_mlfd_checker (.*);

// ===== test/tb_magic_length_frame_detector_top.sv =====
// ----------------------------------------------------------------------------
// Magic length frame detector testbench
// Drives words through the valid/stall input, checks each reported frame
// against a behavioral tracker of the header window, and walks the length
// limit register through several values, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_magic_length_frame_detector_top;
	import mlfd_pkg::*;

	localparam int          CLK_HALF      = 10;
	localparam int          RESET_CYCLES  = 12;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          HOLD_CYCLES   = 300;
	localparam longint      TIMEOUT_NS    = 20_000_000;
	localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
	localparam logic [2:0]  ADDR_MAX_LEN  = 3'd0;

	typedef struct packed {
		logic [LEN_W-1:0] pl;
		logic [LEN_W-1:0] fl;
	} frame_report_t;

	typedef struct packed {
		logic [1:0]    f;
		logic [7:0]    b;
		bit            given;
		frame_report_t want;
	} dir_row_t;

	localparam frame_report_t NO_REPORT = '0;
	localparam int            DIR_ROWS  = 21;

	// short directed frame: unused code, idle byte, one-byte payload, late bytes
	localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
		'{FUNC_UNUSED, 8'h5A, 1'b0, NO_REPORT},
		'{FUNC_BYTE,   8'hFF, 1'b0, NO_REPORT},
		'{FUNC_ARM,    8'h00, 1'b0, NO_REPORT},
		'{FUNC_BYTE, MAGIC_TEXT[0], 1'b0, NO_REPORT},
		'{FUNC_BYTE, MAGIC_TEXT[1], 1'b0, NO_REPORT},
		'{FUNC_BYTE, MAGIC_TEXT[2], 1'b0, NO_REPORT},
		'{FUNC_BYTE, MAGIC_TEXT[3], 1'b0, NO_REPORT},
		'{FUNC_BYTE, MAGIC_TEXT[4], 1'b0, NO_REPORT},
		'{FUNC_BYTE, MAGIC_TEXT[5], 1'b0, NO_REPORT},
		'{FUNC_BYTE, MAGIC_TEXT[6], 1'b0, NO_REPORT},
		'{FUNC_BYTE, MAGIC_TEXT[7], 1'b0, NO_REPORT},
		'{FUNC_BYTE,   8'h00, 1'b0, NO_REPORT},
		'{FUNC_BYTE,   CH_PLUS, 1'b0, NO_REPORT},
		'{FUNC_BYTE,   8'h31, 1'b0, NO_REPORT},
		'{FUNC_BYTE,   CH_TAB, 1'b0, NO_REPORT},
		'{FUNC_BYTE,   CH_SPACE, 1'b0, NO_REPORT},
		'{FUNC_BYTE,   8'hFF, 1'b0, NO_REPORT},
		'{FUNC_BYTE,   8'hA5, 1'b1, '{14'd1, 14'd15}},
		'{FUNC_BYTE,   8'h00, 1'b0, NO_REPORT},
		'{FUNC_DISARM, 8'h00, 1'b0, NO_REPORT},
		'{FUNC_BYTE,   8'hFF, 1'b0, NO_REPORT}
	};

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       func;
	logic [7:0]       rx_byte;
	logic             out_valid;
	logic             out_stall;
	logic [LEN_W-1:0] payload_len;
	logic [LEN_W-1:0] frame_len;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [2:0]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;

	// tracker state
	logic [7:0]       mdl_win [HEADER_BYTES];
	int               mdl_fill;
	bit               mdl_armed;
	bit               mdl_locked;
	bit               mdl_done;
	logic [LEN_W-1:0] mdl_decl;
	logic [LEN_W-1:0] mdl_seen;
	logic [LEN_W-1:0] cfg_max_len;

	frame_report_t    frames_due [$];
	int               err_count;
	int               words_sent;
	bit               gaps_allowed;
	bit               tx_gaps;
	bit               rx_gaps;
	bit               hold_req;

	magic_length_frame_detector_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.payload_len (payload_len),
		.frame_len   (frame_len),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= 100)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic drop_front(input int n);
		if (n >= mdl_fill) begin
			mdl_fill = 0;
		end else begin
			for (int i = 0; i < mdl_fill - n; i++)
				mdl_win[i] = mdl_win[i + n];
			mdl_fill -= n;
		end
	endtask

	// header window tracker: one word in, at most one frame report out
	task automatic follow_stream(input logic [1:0] f, input logic [7:0] b, output bit got,
			output logic [LEN_W-1:0] pl, output logic [LEN_W-1:0] fl);
		int val;
		int pos;
		bit neg;
		bit lead;
		got = 1'b0;
		pl = '0;
		fl = '0;
		case (f)
			FUNC_ARM: begin
				for (int i = 0; i < HEADER_BYTES; i++)
					mdl_win[i] = 8'h00;
				mdl_fill = 0;
				mdl_armed = 1'b1;
				mdl_locked = 1'b0;
				mdl_decl = '0;
				mdl_seen = '0;
				mdl_done = 1'b0;
			end
			FUNC_DISARM: mdl_armed = 1'b0;
			FUNC_BYTE: if (mdl_armed && !mdl_done) begin
				if (mdl_locked) begin
					// payload counting, 14-bit wrap
					mdl_seen = mdl_seen + 1'b1;
					if (mdl_seen >= mdl_decl) begin
						mdl_done = 1'b1;
						got = 1'b1;
						pl = mdl_decl;
						fl = mdl_decl + LEN_W'(HEADER_BYTES);
					end
				end else begin
					if (mdl_fill < HEADER_BYTES) begin
						mdl_win[mdl_fill] = b;
						mdl_fill++;
					end
					if (mdl_fill == HEADER_BYTES) begin
						lead = 1'b1;
						for (int i = 0; i < MAGIC_BYTES; i++)
							if (mdl_win[i] != MAGIC_TEXT[i])
								lead = 1'b0;
						if (!lead) begin
							drop_front(1);
						end else begin
							// whitespace, optional sign, digits
							pos = LEN_POS;
							neg = 1'b0;
							val = 0;
							while (pos < LEN_END && (mdl_win[pos] == CH_SPACE ||
									(mdl_win[pos] >= CH_TAB && mdl_win[pos] <= CH_CR)))
								pos++;
							if (pos < LEN_END &&
									(mdl_win[pos] == CH_PLUS || mdl_win[pos] == CH_MINUS)) begin
								neg = (mdl_win[pos] == CH_MINUS);
								pos++;
							end
							while (pos < LEN_END && mdl_win[pos] >= CH_ZERO &&
									mdl_win[pos] <= CH_NINE) begin
								val = val * 10 + int'(mdl_win[pos] - CH_ZERO);
								pos++;
							end
							if (neg || val == 0 || val > int'(cfg_max_len)) begin
								drop_front(MAGIC_BYTES);
							end else begin
								mdl_locked = 1'b1;
								mdl_decl = val[LEN_W-1:0];
								mdl_seen = '0;
							end
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// one word through the input handshake; prediction made up front
	task automatic send_word(input logic [1:0] f, input logic [7:0] b, input bit given,
			input frame_report_t want);
		bit got;
		logic [LEN_W-1:0] pl;
		logic [LEN_W-1:0] fl;
		follow_stream(f, b, got, pl, fl);
		if (given)
			frames_due.push_back(want);
		else if (got)
			frames_due.push_back(frame_report_t'{pl, fl});
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(FUNC_BYTE, b, 1'b0, NO_REPORT);
	endtask

	function automatic logic [7:0] ws_char();
		return ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(9, 13));
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 6)
			return $urandom_range(1, 12);
		if (r == 7)
			return (cfg_max_len >= 1 && cfg_max_len <= 300) ? int'(cfg_max_len) :
				$urandom_range(1, 12);
		if (r == 8)
			return (cfg_max_len < 9999) ? int'(cfg_max_len) + 1 : $urandom_range(13, 40);
		return $urandom_range(1, 9999);
	endfunction

	// four length characters in one of several shapes
	task automatic make_len_field(input int n, input bit plain, output logic [3:0][7:0] fld);
		int style;
		int d;
		int p;
		int v;
		int k;
		style = plain ? 0 : $urandom_range(0, 9);
		d = (n < 10) ? 1 : (n < 100) ? 2 : (n < 1000) ? 3 : 4;
		fld = {4{CH_SPACE}};
		if (style <= 5) begin
			// whitespace, maybe '+' or a leading zero, digits, then a terminator
			p = 0;
			k = $urandom_range(0, 4 - d);
			repeat (k) begin
				fld[p] = ws_char();
				p++;
			end
			if (p < 4 - d && $urandom_range(0, 1) != 0) begin
				fld[p] = ($urandom_range(0, 1) != 0) ? CH_PLUS : CH_ZERO;
				p++;
			end
			v = n;
			for (int i = d - 1; i >= 0; i--) begin
				fld[p + i] = CH_ZERO + 8'(v % 10);
				v = v / 10;
			end
			p += d;
			if (p < 4) begin
				case ($urandom_range(0, 5))
					0: fld[p] = CH_SPACE;
					1: fld[p] = 8'h00;
					2: fld[p] = 8'hFF;
					3: fld[p] = 8'h2E;
					4: fld[p] = CH_MINUS;
					default: fld[p] = 8'h78;
				endcase
				for (int i = p + 1; i < 4; i++)
					fld[i] = 8'($urandom_range(0, 255));
			end
		end else if (style == 6) begin
			// negative number
			p = $urandom_range(0, 1);
			if (p != 0)
				fld[0] = ws_char();
			fld[p] = CH_MINUS;
			for (int i = p + 1; i < 4; i++)
				fld[i] = CH_ZERO + 8'($urandom_range(0, 9));
		end else if (style == 7) begin
			// signs and near-miss characters, no digit at all
			for (int i = 0; i < 4; i++)
				case ($urandom_range(0, 8))
					0: fld[i] = ws_char();
					1: fld[i] = CH_PLUS;
					2: fld[i] = CH_MINUS;
					3: fld[i] = 8'h08;
					4: fld[i] = 8'h0E;
					5: fld[i] = 8'h1F;
					6: fld[i] = 8'h2F;
					7: fld[i] = 8'h3A;
					default: fld[i] = 8'h61;
				endcase
		end else if (style == 8) begin
			// zero value
			for (int i = 0; i < 4; i++)
				fld[i] = ($urandom_range(0, 1) != 0) ? CH_ZERO : CH_SPACE;
		end else begin
			// loose mix or raw noise
			k = $urandom_range(0, 1);
			for (int i = 0; i < 4; i++)
				if (k != 0)
					case ($urandom_range(0, 3))
						0: fld[i] = ws_char();
						1: fld[i] = ($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS;
						default: fld[i] = CH_ZERO + 8'($urandom_range(0, 9));
					endcase
				else
					fld[i] = 8'($urandom_range(0, 255));
		end
	endtask

	// one frame attempt: optional noise, arm, prefix junk, header, payload
	task automatic gen_frame(input int forced);
		int n;
		int k;
		int need;
		int bad;
		logic [3:0][7:0] fld;
		tx_gaps = gaps_allowed && forced == 0 && $urandom_range(0, 3) != 0;
		rx_gaps = gaps_allowed && $urandom_range(0, 3) != 0;
		if (forced == 0 && $urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 4))
				send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0,
					NO_REPORT);
		if (forced != 0 || $urandom_range(0, 9) != 0)
			send_word(FUNC_ARM, 8'($urandom_range(0, 255)), 1'b0, NO_REPORT);
		if (forced == 0 && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6))
				send_byte(($urandom_range(0, 1) != 0) ? MAGIC_TEXT[0] :
					8'($urandom_range(0, 255)));
		bad = (forced == 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : -1;
		for (int i = 0; i < MAGIC_BYTES; i++)
			send_byte((i == bad) ? MAGIC_TEXT[i] ^ 8'($urandom_range(1, 255)) : MAGIC_TEXT[i]);
		send_byte(8'($urandom_range(0, 255)));
		n = (forced != 0) ? forced : pick_len();
		make_len_field(n, forced != 0, fld);
		for (int i = 0; i < 4; i++)
			send_byte(fld[i]);
		send_byte(8'($urandom_range(0, 255)));
		if (mdl_armed && mdl_locked && !mdl_done) begin
			need = int'(mdl_decl) - int'(mdl_seen);
			// long payloads are cut short except when asked for
			if (forced == 0 && (need > 600 || $urandom_range(0, 11) == 0))
				k = $urandom_range(0, (need > 20) ? 20 : need - 1);
			else
				k = need + ((forced == 0 && $urandom_range(0, 3) == 0) ?
					$urandom_range(1, 3) : 0);
		end else begin
			k = $urandom_range(0, 3);
		end
		repeat (k) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic run_frames(input int count);
		int start;
		start = words_sent;
		while (words_sent - start < count)
			gen_frame(0);
	endtask

	// wait for every report, then let the pipeline empty
	task automatic drain();
		in_valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(input bit wr, input logic [31:0] wd, output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_MAX_LEN;
		pwdata <= wd;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_max_len(input logic [LEN_W-1:0] v);
		logic [31:0] rd;
		drain();
		apb_xfer(1'b1, {18'd0, v}, rd);
		apb_xfer(1'b0, 32'd0, rd);
		if (rd !== {18'd0, v})
			flag_error($sformatf("max_payload_len reads %0d, wrote %0d", rd, v));
		cfg_max_len = v;
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin : receiver
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	// report check against the oldest expectation
	always @(posedge clk) begin : check_reports
		frame_report_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				flag_error($sformatf("unexpected report payload_len=%0d frame_len=%0d",
					payload_len, frame_len));
			end else begin
				exp_r = frames_due.pop_front();
				if (payload_len !== exp_r.pl)
					flag_error($sformatf("payload_len %0d, expected %0d", payload_len, exp_r.pl));
				if (frame_len !== exp_r.fl)
					flag_error($sformatf("frame_len %0d, expected %0d", frame_len, exp_r.fl));
			end
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] rd;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_BYTE;
		rx_byte = 8'h00;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_MAX_LEN;
		pwdata = 32'd0;
		err_count = 0;
		words_sent = 0;
		hold_req = 1'b0;
		gaps_allowed = 1'b1;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		for (int i = 0; i < HEADER_BYTES; i++)
			mdl_win[i] = 8'h00;
		mdl_fill = 0;
		mdl_armed = 1'b0;
		mdl_locked = 1'b0;
		mdl_done = 1'b0;
		mdl_decl = '0;
		mdl_seen = '0;
		cfg_max_len = MAX_LEN_RESET;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register reset value
		apb_xfer(1'b0, 32'd0, rd);
		if (rd !== {18'd0, MAX_LEN_RESET})
			flag_error($sformatf("max_payload_len after reset reads %0d", rd));

		for (int i = 0; i < DIR_ROWS; i++)
			send_word(DIR_TBL[i].f, DIR_TBL[i].b, DIR_TBL[i].given, DIR_TBL[i].want);

		// reset limit; a short frame completes into a long receiver hold-off
		run_frames(250);
		hold_req = 1'b1;
		gen_frame(3);
		run_frames(200);

		set_max_len(14'd1);
		run_frames(250);

		// widest limit with one full frame longer than the reset limit
		set_max_len(14'd9999);
		gen_frame(300);
		run_frames(100);

		// nothing passes
		set_max_len(14'd0);
		run_frames(150);

		set_max_len(14'($urandom_range(2, 9998)));
		run_frames(300);

		// closing stretch without idling
		gaps_allowed = 1'b0;
		set_max_len(14'd20);
		run_frames(300);
		drain();

		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mlfd_pkg.sv
rtl/core/mlfd_front.sv
rtl/core/mlfd_queue.sv
rtl/core/mlfd_back.sv
rtl/core/magic_length_frame_detector_top.sv
rtl/core/mlfd_checker.sv
test/tb_magic_length_frame_detector_top.sv
